/* hdl/rakt_pkg.sv */
// rakt_pkg: shared types, sizes and codes for the rolling access key table
// used by rakt_scan, rolling_access_key_table and the testbench; no dependencies
package rakt_pkg;

   // table geometry
   localparam int SLOTS      = 16;
   localparam int KEY_OCTETS = 8;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = SLOT_W + 1;
   localparam int KEY_W      = 64;
   // wide enough to compare any slot_index against any table size below 512
   localparam int IDX_CMP_W  = 9;

   // only the low KEY_OCTETS bytes of a key take part
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_OCTETS);

   typedef logic [1:0]        cmd_type;
   typedef logic [3:0]        idx_type;
   typedef logic [2:0]        status_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // commands
   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_AUTH   = 2'd1;
   localparam cmd_type CMD_ENROLL = 2'd2;
   localparam cmd_type CMD_COMMIT = 2'd3;

   // result status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_NO_MARKER = 3'd1;
   localparam status_type ST_DENIED    = 3'd2;
   localparam status_type ST_COLLIDES  = 3'd3;
   localparam status_type ST_ALL_ONES  = 3'd4;
   localparam status_type ST_FULL      = 3'd5;

   // outcome of one pass over the table
   typedef struct packed {
      logic     done;
      logic     match_found;
      slot_type match_slot;
      logic     free_found;
      slot_type vacant_slot;
      logic     cand_hit;
   } scan_res_type;

endpackage

/* hdl/rakt_ram.sv */
// rakt_ram: generic single write port, single read port ram with registered read
// no package dependencies
module rakt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rakt_scan.sv */
// rakt_scan: walks the key ram one slot per cycle, tracking the lowest matching
// slot, the lowest free slot and any candidate collision; uses rakt_pkg
module rakt_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  rakt_pkg::key_type         key,
   input  rakt_pkg::key_type         cand,
   input  logic [rakt_pkg::SLOTS-1:0] valid,
   input  rakt_pkg::key_type         rd_data,
   output logic                      rd_en,
   output rakt_pkg::slot_type        rd_addr,
   output rakt_pkg::scan_res_type    res
);
   import rakt_pkg::*;

   logic     active_ff, active_in;
   cnt_type  iss_ff, iss_in;
   logic     pend_ff, pend_in;
   slot_type pidx_ff, pidx_in;
   logic     match_found_ff, match_found_in;
   slot_type match_slot_ff, match_slot_in;
   logic     free_found_ff, free_found_in;
   slot_type vacant_slot_ff, vacant_slot_in;
   logic     cand_hit_ff, cand_hit_in;
   logic     more;
   logic     slot_ok;
   logic     done;

   // read issue side
   assign more    = (iss_ff < cnt_type'(SLOTS));
   assign rd_en   = active_ff && more;
   assign rd_addr = iss_ff[SLOT_W-1:0];
   assign slot_ok = valid[pidx_ff];
   assign done    = active_ff && !more && pend_ff;

   // issue counter, compare stage and trackers
   always_comb begin
      active_in      = active_ff;
      iss_in         = iss_ff;
      pend_in        = 1'b0;
      pidx_in        = pidx_ff;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      free_found_in  = free_found_ff;
      vacant_slot_in = vacant_slot_ff;
      cand_hit_in    = cand_hit_ff;
      if (start) begin
         active_in      = 1'b1;
         iss_in         = '0;
         match_found_in = 1'b0;
         match_slot_in  = '0;
         free_found_in  = 1'b0;
         vacant_slot_in = '0;
         cand_hit_in    = 1'b0;
      end else if (active_ff) begin
         if (more) begin
            iss_in  = iss_ff + cnt_type'(1);
            pend_in = 1'b1;
            pidx_in = iss_ff[SLOT_W-1:0];
         end
         // slot data from last cycle's read
         if (pend_ff) begin
            if (slot_ok && rd_data == key && !match_found_ff) begin
               match_found_in = 1'b1;
               match_slot_in  = pidx_ff;
            end
            if (!slot_ok && !free_found_ff) begin
               free_found_in  = 1'b1;
               vacant_slot_in = pidx_ff;
            end
            if (slot_ok && rd_data == cand) begin
               cand_hit_in = 1'b1;
            end
         end
         if (done) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff         <= iss_in;
      pidx_ff        <= pidx_in;
      match_found_ff <= match_found_in;
      match_slot_ff  <= match_slot_in;
      free_found_ff  <= free_found_in;
      vacant_slot_ff <= vacant_slot_in;
      cand_hit_ff    <= cand_hit_in;
   end

   assign res.done        = done;
   assign res.match_found = match_found_ff;
   assign res.match_slot  = match_slot_ff;
   assign res.free_found  = free_found_ff;
   assign res.vacant_slot = vacant_slot_ff;
   assign res.cand_hit    = cand_hit_ff;

endmodule

/* hdl/rolling_access_key_table.sv */
// rolling_access_key_table: top level, command decode, valid bits and result register
// load, commit and authenticate without marker give their result in the cycle after
// the item is taken; short items are taken one per cycle while the result register is
// free; authenticate with marker and enroll walk the key ram's single read port one slot
// per cycle and hold off new items until their result is registered; reset clears
// the valid bits and control state, not the key ram; uses rakt_pkg, rakt_ram, rakt_scan
module rolling_access_key_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rakt_pkg::cmd_type    req_command,
   input  rakt_pkg::idx_type    req_slot_index,
   input  rakt_pkg::key_type    req_presented_key,
   input  logic                 req_marker_ok,
   input  rakt_pkg::key_type    req_candidate_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rakt_pkg::status_type rsp_status,
   output rakt_pkg::idx_type    rsp_found_slot,
   output rakt_pkg::key_type    rsp_new_key
);
   import rakt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   cmd_type          cmd_ff, cmd_in;
   key_type          key_ff, key_in;
   key_type          cand_ff, cand_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   idx_type          slot_ff, slot_in;
   key_type          new_key_ff, new_key_in;

   logic         rsp_free;
   logic         accept;
   logic         is_write;
   logic         in_range;
   key_type      req_key_m;
   key_type      req_cand_m;
   slot_type     wr_slot;
   logic         start;
   logic         ram_rd_en;
   slot_type     ram_rd_addr;
   key_type      ram_rd_data;
   scan_res_type scan_res;
   logic         slot_found;
   slot_type     pick_slot;

   // handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && rsp_free);
   assign accept    = req_valid && !req_stall;

   // decode of the incoming item
   assign req_key_m  = req_presented_key & KEY_MASK;
   assign req_cand_m = req_candidate_key & KEY_MASK;
   assign is_write   = (req_command == CMD_LOAD) || (req_command == CMD_COMMIT);
   assign in_range   = IDX_CMP_W'(req_slot_index) < IDX_CMP_W'(SLOTS);
   assign wr_slot    = SLOT_W'(req_slot_index);
   assign start      = accept && !is_write && (req_command == CMD_ENROLL || req_marker_ok);

   // key storage
   rakt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (accept && is_write && in_range),
      .wr_addr (wr_slot),
      .wr_data (req_key_m),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rakt_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .key     (key_ff),
      .cand    (cand_ff),
      .valid   (valid_ff),
      .rd_data (ram_rd_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .res     (scan_res)
   );

   // scan outcome for the pending command
   assign slot_found = (cmd_ff == CMD_AUTH) ? scan_res.match_found : scan_res.free_found;
   assign pick_slot  = (cmd_ff == CMD_AUTH) ? scan_res.match_slot : scan_res.vacant_slot;

   // sequencing, valid bits and result register
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      slot_in      = slot_ff;
      new_key_in   = new_key_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               key_in  = req_key_m;
               cand_in = req_cand_m;
               if (is_write) begin
                  rsp_valid_in = 1'b1;
                  slot_in      = '0;
                  new_key_in   = '0;
                  if (in_range) begin
                     status_in = ST_OK;
                     valid_in[wr_slot] = (req_command == CMD_COMMIT) || (req_key_m != KEY_MASK);
                  end else begin
                     status_in = ST_DENIED;
                  end
               end else if (start) begin
                  state_in = S_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_NO_MARKER;
                  slot_in      = '0;
                  new_key_in   = '0;
               end
            end
         end
         S_SCAN: begin
            if (scan_res.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               new_key_in   = '0;
               if (!slot_found) begin
                  status_in = (cmd_ff == CMD_AUTH) ? ST_DENIED : ST_FULL;
                  slot_in   = '0;
               end else begin
                  slot_in = idx_type'(pick_slot);
                  if (cand_ff == KEY_MASK) begin
                     status_in = ST_ALL_ONES;
                  end else if (scan_res.cand_hit) begin
                     status_in = ST_COLLIDES;
                  end else begin
                     status_in  = ST_OK;
                     new_key_in = cand_ff;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      cand_ff    <= cand_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      new_key_ff <= new_key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_slot = slot_ff;
   assign rsp_new_key    = new_key_ff;

endmodule

/* test/testbench.sv */
// testbench for rolling_access_key_table: directed table then random traffic,
// checked against an in-bench predictor of the key table or typed answers; depends on rakt_pkg
`timescale 1ns / 100ps

module testbench;
   import rakt_pkg::*;

   localparam key_type KEY_ONES = '1;

   // one request item, with an optional hand-typed answer for directed rows
   typedef struct packed {
      cmd_type    cmd;
      idx_type    slot;
      key_type    key;
      logic       marker;
      key_type    cand;
      logic       fixed;
      status_type st;
      idx_type    at;
      key_type    nk;
   } key_op_type;

   typedef struct packed {
      status_type st;
      idx_type    at;
      key_type    nk;
   } key_answer_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   cmd_type    req_command;
   idx_type    req_slot_index;
   key_type    req_presented_key;
   logic       req_marker_ok;
   key_type    req_candidate_key;
   logic       rsp_valid;
   logic       rsp_stall;
   status_type rsp_status;
   idx_type    rsp_found_slot;
   key_type    rsp_new_key;

   // predictor copy of the table
   key_type        key_bank [SLOTS];
   logic           slot_live [SLOTS] = '{default: 1'b0};
   key_answer_type answers_due [$];
   key_answer_type last_answer;
   key_answer_type head_answer;
   key_type        key_pool [8];
   key_op_type     directed_ops [0:25];
   int             burst_left = 0;
   int             fault_count = 0;
   int             cmd_count [4] = '{default: 0};
   int             status_count [6] = '{default: 0};

   rolling_access_key_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_slot_index    (req_slot_index),
      .req_presented_key (req_presented_key),
      .req_marker_ok     (req_marker_ok),
      .req_candidate_key (req_candidate_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_slot    (rsp_found_slot),
      .rsp_new_key       (rsp_new_key)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic key_type random_key();
      return {$urandom, $urandom};
   endfunction

   // lowest live slot holding key k, or -1
   function automatic int live_match(key_type k);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && key_bank[i] == k) return i;
      end
      return -1;
   endfunction

   // key of a random live slot, fresh key when the table is empty
   function automatic key_type live_key();
      int n;
      int pick;
      n = 0;
      foreach (slot_live[i]) if (slot_live[i]) n++;
      if (n == 0) return random_key();
      pick = $urandom_range(0, n - 1);
      foreach (slot_live[i]) begin
         if (slot_live[i]) begin
            if (pick == 0) return key_bank[i];
            pick--;
         end
      end
      return random_key();
   endfunction

   // key for load or commit: all ones at the given percentage, else pool or fresh
   function automatic key_type written_key(int ones_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ones_pct) return KEY_ONES;
      if (r < ones_pct + 30) return key_pool[$urandom_range(0, 7)];
      return random_key();
   endfunction

   // answer of the key table to one item; updates the table copy
   function automatic key_answer_type table_answer(key_op_type op);
      key_answer_type a;
      key_type        key;
      key_type        cand;
      int             hit;
      a = '0;
      key = op.key & KEY_MASK;
      cand = op.cand & KEY_MASK;
      hit = -1;
      case (op.cmd)
         CMD_LOAD, CMD_COMMIT: begin
            if (int'(op.slot) < SLOTS) begin
               key_bank[op.slot] = key;
               slot_live[op.slot] = (op.cmd == CMD_COMMIT) || (key != KEY_MASK);
            end else begin
               a.st = ST_DENIED;
            end
         end
         CMD_AUTH: begin
            if (!op.marker) begin
               a.st = ST_NO_MARKER;
            end else begin
               hit = live_match(key);
               if (hit < 0) a.st = ST_DENIED;
            end
         end
         CMD_ENROLL: begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) hit = i;
            end
            if (hit < 0) a.st = ST_FULL;
         end
         default: begin
         end
      endcase
      // candidate checks: all ones first, then any live slot
      if (hit >= 0) begin
         a.at = idx_type'(hit);
         if (cand == KEY_MASK) begin
            a.st = ST_ALL_ONES;
         end else if (live_match(cand) >= 0) begin
            a.st = ST_COLLIDES;
         end else begin
            a.st = ST_OK;
            a.nk = cand;
         end
      end
      return a;
   endfunction

   // present one item in bursts with random gaps, record it once taken
   task automatic send_op(input key_op_type op);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid         <= 1'b1;
      req_command       <= op.cmd;
      req_slot_index    <= op.slot;
      req_presented_key <= op.key;
      req_marker_ok     <= op.marker;
      req_candidate_key <= op.cand;
      do @(posedge clock); while (req_stall);
      last_answer = table_answer(op);
      if (op.fixed) answers_due.push_back(key_answer_type'{op.st, op.at, op.nk});
      else answers_due.push_back(last_answer);
      cmd_count[op.cmd]++;
      burst_left--;
      @(negedge clock);
   endtask

   // hold the sender until every answer is back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (answers_due.size() != 0);
   endtask

   // random item: mostly table-aware keys, some noise
   task automatic random_op(output key_op_type op);
      int pick;
      int r;
      op = '0;
      op.slot = idx_type'($urandom);
      op.marker = ($urandom_range(0, 9) != 0);
      op.key = random_key();
      r = $urandom_range(0, 99);
      if (r < 70) op.cand = random_key();
      else if (r < 85) op.cand = live_key();
      else if (r < 93) op.cand = KEY_ONES;
      else op.cand = key_pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         op.cmd = CMD_AUTH;
         r = $urandom_range(0, 99);
         if (r < 70) op.key = live_key();
         else if (r < 80) op.key = KEY_ONES;
         else if (r < 90) op.key = key_pool[$urandom_range(0, 7)];
      end else if (pick < 55) begin
         op.cmd = CMD_ENROLL;
      end else if (pick < 80) begin
         op.cmd = CMD_COMMIT;
         op.key = written_key(5);
      end else begin
         op.cmd = CMD_LOAD;
         op.key = written_key(50);
      end
   endtask

   // receiver stall pattern: free, light and heavy stretches
   initial begin
      int mode;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 150)) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               default: rsp_stall <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_status <= ST_FULL) status_count[rsp_status]++;
         if (answers_due.size() == 0) begin
            $error("result with no item waiting: status %0d slot %0d key %h",
                   rsp_status, rsp_found_slot, rsp_new_key);
            fault_count++;
         end else begin
            head_answer = answers_due.pop_front();
            if (rsp_status !== head_answer.st) begin
               $error("status: expected %0d, got %0d", head_answer.st, rsp_status);
               fault_count++;
            end
            if (rsp_found_slot !== head_answer.at) begin
               $error("found_slot: expected %0d, got %0d", head_answer.at, rsp_found_slot);
               fault_count++;
            end
            if (rsp_new_key !== head_answer.nk) begin
               $error("new_key: expected %h, got %h", head_answer.nk, rsp_new_key);
               fault_count++;
            end
         end
      end
   end

   initial begin
      key_op_type op;
      logic       follow_up;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = CMD_LOAD;
      req_slot_index    = '0;
      req_presented_key = '0;
      req_marker_ok     = 1'b0;
      req_candidate_key = '0;
      follow_up         = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = 64'h8000_0000_0000_0000;
      for (int i = 2; i < 8; i++) key_pool[i] = random_key();

      // cmd, slot, key, marker, candidate, typed, status, slot, new key
      directed_ops = '{
         // empty table: no marker, no match, enroll candidate checks
         '{CMD_AUTH, 4'd0, 64'h0, 1'b0, 64'h0, 1'b1, ST_NO_MARKER, 4'd0, 64'h0},
         '{CMD_AUTH, 4'd0, 64'h0, 1'b1, 64'h0, 1'b1, ST_DENIED, 4'd0, 64'h0},
         '{CMD_ENROLL, 4'd0, 64'h0, 1'b1, KEY_ONES, 1'b1, ST_ALL_ONES, 4'd0, 64'h0},
         '{CMD_ENROLL, 4'd0, 64'h0, 1'b0, 64'h1, 1'b1, ST_OK, 4'd0, 64'h1},
         // all-ones load leaves slot 1 free
         '{CMD_LOAD, 4'd1, KEY_ONES, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd0, 64'h0, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd2, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd3, 64'h0123_4567_89AB_CDEF, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd4, 64'h0000_0000_0000_0001, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd5, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd6, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd7, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd8, 64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         // same key as slot 3, so a match must pick the lower slot
         '{CMD_COMMIT, 4'd9, 64'h0123_4567_89AB_CDEF, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd10, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd11, 64'h1111_2222_3333_4444, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd12, 64'h8765_4321_0FED_CBA9, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd13, 64'h00FF_00FF_00FF_00FF, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd14, 64'hFF00_FF00_FF00_FF00, 1'b0, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         // all-ones commit still makes the slot live
         '{CMD_COMMIT, 4'd15, KEY_ONES, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_ENROLL, 4'd0, 64'h0, 1'b1, 64'h5, 1'b0, ST_OK, 4'd0, 64'h0},
         '{CMD_COMMIT, 4'd1, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b1, ST_OK, 4'd0, 64'h0},
         '{CMD_ENROLL, 4'd0, 64'h0, 1'b1, 64'h6, 1'b1, ST_FULL, 4'd0, 64'h0},
         // candidate equal to the matched slot's own key
         '{CMD_AUTH, 4'd0, 64'h0, 1'b1, 64'h0, 1'b1, ST_COLLIDES, 4'd0, 64'h0},
         // all-ones candidate refused before the collision check
         '{CMD_AUTH, 4'd0, KEY_ONES, 1'b1, KEY_ONES, 1'b1, ST_ALL_ONES, 4'd15, 64'h0},
         '{CMD_AUTH, 4'd0, 64'h0123_4567_89AB_CDEF, 1'b1, 64'hC3C3_3C3C_A5A5_5A5A, 1'b0,
           ST_OK, 4'd0, 64'h0}
      };

      // hold synchronous reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_ops[i]) send_op(directed_ops[i]);
      wait_for_answers();

      // random traffic; accepted candidates are usually committed right after
      for (int n = 0; n < 800; n++) begin
         if (n == 400) wait_for_answers();
         if (follow_up) begin
            op = '0;
            op.cmd = CMD_COMMIT;
            op.slot = last_answer.at;
            op.key = last_answer.nk;
            op.marker = $urandom_range(0, 1);
            op.cand = random_key();
         end else begin
            random_op(op);
         end
         send_op(op);
         follow_up = (op.cmd == CMD_AUTH || op.cmd == CMD_ENROLL) &&
                     last_answer.st == ST_OK && $urandom_range(0, 99) < 85;
      end
      req_valid <= 1'b0;

      // drain, then give a stray result time to show up
      while (answers_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d results never arrived", answers_due.size());
         fault_count++;
      end
      $display("items taken: %0d load, %0d authenticate, %0d enroll, %0d commit",
               cmd_count[CMD_LOAD], cmd_count[CMD_AUTH], cmd_count[CMD_ENROLL],
               cmd_count[CMD_COMMIT]);
      $display("answers seen: ok %0d, no marker %0d, denied %0d, collides %0d, ones %0d, full %0d",
               status_count[ST_OK], status_count[ST_NO_MARKER], status_count[ST_DENIED],
               status_count[ST_COLLIDES], status_count[ST_ALL_ONES], status_count[ST_FULL]);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout: %0d results still outstanding", answers_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
